// ===== rtl/circular_deque_defines.svh =====
// Assertion macros shared by the circular deque RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("circular_deque: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("circular_deque: assertion failed");

`endif

// ===== rtl/cdq_pkg.sv =====
// Types and constants for the circular deque.
// No dependencies; imported by circular_deque.
package cdq_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IN_W     = 40;
  localparam int unsigned OUT_W    = 72;

  localparam logic [FUNC_W-1:0] OP_PEEK       = 3'd0;
  localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [WORD_W-1:0] WORD_NONE = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_FIN
  } state_t;

endpackage

// ===== rtl/circular_deque.sv =====
// Top level of the circular deque: pointer control, two mirrored ring RAMs, result register.
// Depends on cdq_pkg, cdq_ram and circular_deque_defines.svh.
//
// A double-ended queue of DEPTH signed 32-bit words. Each input beat carries one
// operation (peek, push front, push back, pop front, pop back) and yields exactly one
// result beat with a status, the empty and full flags, and the front and rear words
// after the operation (all ones when empty). An item passes three states: the accept
// state updates the pointers and writes the pushed word, the read state reads the new
// front and rear entries from two mirrored RAMs, and the finish state loads the result
// register once the output is free. The input accepts a new beat while a finished
// result still waits on the output, but only after the last item has loaded that register.
module circular_deque #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: func[2:0], push_value[34:3], zero fill[39:35].
  input  logic [cdq_pkg::IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: status[1:0], is_empty[2], is_full[3], front_value[35:4],
  // rear_value[67:36], zero fill[71:68].
  output logic [cdq_pkg::OUT_W-1:0] out_tdata
);

  import cdq_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  state_t              state_r, state_nxt;
  logic [PW-1:0]       head_r, head_nxt;
  logic [PW-1:0]       tail_r, tail_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  logic [FUNC_W-1:0]   in_func;
  logic [WORD_W-1:0]   in_word;
  logic                in_acc;
  logic                wr_en;
  logic [PW-1:0]       wr_addr;
  logic                rd_en;
  logic [WORD_W-1:0]   front_rd;
  logic [WORD_W-1:0]   rear_rd;
  logic [WORD_W-1:0]   front_val;
  logic [WORD_W-1:0]   rear_val;
  logic                q_empty;
  logic                q_full;

  assign in_func   = in_tdata[FUNC_W-1:0];
  assign in_word   = in_tdata[FUNC_W+WORD_W-1:FUNC_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign rd_en     = (state_r == S_RD);
  assign q_empty   = (cnt_r == '0);
  assign q_full    = (cnt_r == CNT_FULL);
  assign front_val = q_empty ? WORD_NONE : front_rd;
  assign rear_val  = q_empty ? WORD_NONE : rear_rd;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt  = S_RD;
          status_nxt = ST_DONE;
          if (in_func == OP_PUSH_FRONT || in_func == OP_PUSH_BACK) begin
            if (q_full) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
              if (q_empty) begin
                head_nxt = '0;
                tail_nxt = '0;
                wr_addr  = '0;
              end else if (in_func == OP_PUSH_FRONT) begin
                head_nxt = (head_r == '0) ? PTR_LAST : head_r - 1'b1;
                wr_addr  = head_nxt;
              end else begin
                tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
                wr_addr  = tail_nxt;
              end
            end
          end else if (in_func == OP_POP_FRONT || in_func == OP_POP_BACK) begin
            if (q_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              cnt_nxt = cnt_r - 1'b1;
              if (cnt_r == CW'(1)) begin
                head_nxt = '0;
                tail_nxt = '0;
              end else if (in_func == OP_POP_FRONT) begin
                head_nxt = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
              end else begin
                tail_nxt = (tail_r == '0) ? PTR_LAST : tail_r - 1'b1;
              end
            end
          end
        end
      end
      S_RD: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OUT_W - 68)'(0), rear_val, front_val, q_full, q_empty, status_r};
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  cdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram_front (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_word),
    .rd_en   (rd_en),
    .rd_addr (head_r),
    .rd_data (front_rd)
  );

  cdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram_rear (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_word),
    .rd_en   (rd_en),
    .rd_addr (tail_r),
    .rd_data (rear_rd)
  );

`include "circular_deque_defines.svh"

  `CDQ_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_FULL)
  `CDQ_ASSERT_IMPL(a_empty_ptrs, clk, rst_n, cnt_r == '0, head_r == '0 && tail_r == '0)
  `CDQ_ASSERT_NEXT(a_acc_reads, clk, rst_n, in_acc, state_r == S_RD)
  `CDQ_ASSERT_IMPL(a_empty_words, clk, rst_n, out_valid_r && out_data_r[2],
    out_data_r[35:4] == WORD_NONE && out_data_r[67:36] == WORD_NONE)

endmodule

// ===== rtl/cdq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; instantiated by circular_deque.
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for circular_deque: directed table, then random pushes, pops and peeks.
// Depends on cdq_pkg and the circular_deque RTL; checks use table values or an in-bench deque.
module tb_top;
  import cdq_pkg::*;

  localparam int DQ_DEPTH = 8;
  localparam int FILL_W = IN_W - FUNC_W - WORD_W;
  localparam int N_RANDOM = 1200;
  localparam int HOLD_CYCLES = 100;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [FUNC_W-1:0] OP_UNUSED_5 = 3'd5;
  localparam logic [FUNC_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [FUNC_W-1:0] OP_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                is_empty;
    logic                is_full;
    logic [WORD_W-1:0]   front;
    logic [WORD_W-1:0]   rear;
  } dq_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] value;
    logic              typed;
    dq_result_t        want;
  } op_row_t;

  localparam dq_result_t UNTYPED = '0;
  localparam dq_result_t EMPTY_OK = '{ST_DONE, 1'b1, 1'b0, WORD_NONE, WORD_NONE};
  localparam dq_result_t EMPTY_REFUSED = '{ST_EMPTY, 1'b1, 1'b0, WORD_NONE, WORD_NONE};
  localparam int N_DIRECTED = 25;

  op_row_t directed_ops [N_DIRECTED] = '{
    '{OP_PEEK,       32'h0000_0000, 1'b1, EMPTY_OK},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b1, EMPTY_REFUSED},
    '{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, EMPTY_REFUSED},
    '{OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1,
      '{ST_DONE, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}},
    '{OP_PUSH_BACK,  32'h8000_0000, 1'b1,
      '{ST_DONE, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000}},
    '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1,
      '{ST_DONE, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000}},
    '{OP_PUSH_BACK,  32'h0000_0000, 1'b1,
      '{ST_DONE, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000}},
    '{OP_PUSH_FRONT, 32'h1111_1111, 1'b0, UNTYPED},
    '{OP_PUSH_BACK,  32'h2222_2222, 1'b0, UNTYPED},
    '{OP_PUSH_FRONT, 32'h3333_3333, 1'b0, UNTYPED},
    '{OP_PUSH_BACK,  32'h4444_4444, 1'b1,
      '{ST_DONE, 1'b0, 1'b1, 32'h3333_3333, 32'h4444_4444}},
    '{OP_PUSH_FRONT, 32'h5555_5555, 1'b1,
      '{ST_FULL, 1'b0, 1'b1, 32'h3333_3333, 32'h4444_4444}},
    '{OP_PUSH_BACK,  32'hAAAA_AAAA, 1'b1,
      '{ST_FULL, 1'b0, 1'b1, 32'h3333_3333, 32'h4444_4444}},
    '{OP_UNUSED_5,   32'h1234_5678, 1'b0, UNTYPED},
    '{OP_UNUSED_6,   32'h8765_4321, 1'b0, UNTYPED},
    '{OP_UNUSED_7,   32'hFFFF_FFFF, 1'b0, UNTYPED},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b0, UNTYPED},
    '{OP_POP_BACK,   32'h0000_0000, 1'b0, UNTYPED},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b0, UNTYPED},
    '{OP_POP_BACK,   32'h0000_0000, 1'b0, UNTYPED},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b0, UNTYPED},
    '{OP_POP_BACK,   32'h0000_0000, 1'b0, UNTYPED},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b0, UNTYPED},
    '{OP_POP_BACK,   32'h0000_0000, 1'b1, EMPTY_OK},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b1, EMPTY_REFUSED}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;

  circular_deque #(.DEPTH(DQ_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [WORD_W-1:0] ring_words [DQ_DEPTH];
  int unsigned head_at;
  int unsigned tail_at;
  int unsigned held;

  dq_result_t expected_results [$];
  logic       cur_typed;
  dq_result_t cur_want;
  bit         long_hold_req;
  int         burst_left;
  int         n_accepted;
  int         n_checked;
  int         n_full_refused;
  int         n_empty_refused;
  int         n_errors;
  int         quiet_cycles;

  function automatic dq_result_t apply_deque_op(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] w);
    dq_result_t r;
    r.status = ST_DONE;
    if (f == OP_PUSH_FRONT || f == OP_PUSH_BACK) begin
      if (held >= DQ_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        if (held == 0) begin
          head_at = 0;
          tail_at = 0;
          ring_words[0] = w;
        end else if (f == OP_PUSH_FRONT) begin
          head_at = (head_at == 0) ? DQ_DEPTH - 1 : head_at - 1;
          ring_words[head_at] = w;
        end else begin
          tail_at = (tail_at >= DQ_DEPTH - 1) ? 0 : tail_at + 1;
          ring_words[tail_at] = w;
        end
        held++;
      end
    end else if (f == OP_POP_FRONT || f == OP_POP_BACK) begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        held--;
        if (held == 0) begin
          head_at = 0;
          tail_at = 0;
        end else if (f == OP_POP_FRONT) begin
          head_at = (head_at >= DQ_DEPTH - 1) ? 0 : head_at + 1;
        end else begin
          tail_at = (tail_at == 0) ? DQ_DEPTH - 1 : tail_at - 1;
        end
      end
    end
    r.is_empty = (held == 0);
    r.is_full = (held >= DQ_DEPTH);
    r.front = (held == 0) ? WORD_NONE : ring_words[head_at];
    r.rear = (held == 0) ? WORD_NONE : ring_words[tail_at];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    dq_result_t want;
    dq_result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        want = apply_deque_op(in_tdata[FUNC_W-1:0], in_tdata[FUNC_W+WORD_W-1:FUNC_W]);
        if (cur_typed) begin
          want = cur_want;
        end
        if (want.status == ST_FULL) n_full_refused++;
        if (want.status == ST_EMPTY) n_empty_refused++;
        expected_results.push_back(want);
        n_accepted++;
      end
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.is_empty = out_tdata[2];
        got.is_full = out_tdata[3];
        got.front = out_tdata[35:4];
        got.rear = out_tdata[67:36];
        if (expected_results.size() == 0) begin
          $error("result beat arrived with nothing expected: %h", out_tdata);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", WORD_W'(want.status), WORD_W'(got.status));
          check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty));
          check_field("is_full", WORD_W'(want.is_full), WORD_W'(got.is_full));
          check_field("front_value", want.front, got.front);
          check_field("rear_value", want.rear, got.rear);
          n_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles without a beat.", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: rotating stall pattern, regenerated now and then, plus long hold-offs on request.
  initial begin : receiver
    logic [15:0] stall_pat;
    int          until_new;
    out_tready = 1'b0;
    stall_pat = '1;
    until_new = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (until_new == 0) begin
          until_new = $urandom_range(32, 96);
          case ($urandom_range(2))
            0: stall_pat = '1;
            1: stall_pat = 16'($urandom);
            default: stall_pat = 16'($urandom & $urandom);
          endcase
          if (stall_pat == '0) stall_pat = 16'h0001;
        end
        until_new--;
        out_tready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] w,
                         input logic typed, input dq_result_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    cur_typed = typed;
    cur_want = want;
    in_tvalid <= 1'b1;
    in_tdata <= {{FILL_W{1'b0}}, w, f};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [FUNC_W-1:0] f;
    logic [WORD_W-1:0] w;
    int                push_pct;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cur_typed = 1'b0;
    cur_want = UNTYPED;
    long_hold_req = 1'b0;
    burst_left = 0;
    push_pct = 50;
    for (int i = 0; i < DQ_DEPTH; i++) ring_words[i] = '0;
    head_at = 0;
    tail_at = 0;
    held = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_ops[i]) begin
      send_op(directed_ops[i].func, directed_ops[i].value, directed_ops[i].typed,
              directed_ops[i].want);
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      if (k == 300 || k == 900) long_hold_req = 1'b1;
      case ($urandom_range(9))
        0: w = 32'h7FFF_FFFF;
        1: w = 32'h8000_0000;
        2: w = WORD_NONE;
        3: w = '0;
        default: w = $urandom;
      endcase
      if ($urandom_range(99) < 4) begin
        f = OP_PEEK;
      end else if ($urandom_range(99) < 2) begin
        case ($urandom_range(2))
          0: f = OP_UNUSED_5;
          1: f = OP_UNUSED_6;
          default: f = OP_UNUSED_7;
        endcase
      end else if ($urandom_range(99) < push_pct) begin
        f = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        f = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
      end
      send_op(f, w, 1'b0, UNTYPED);
    end
    in_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d deque operations and checked %0d result beats.", n_accepted, n_checked);
    $display("Refusals seen: %0d on a full queue, %0d on an empty one; %0d mismatches.",
             n_full_refused, n_empty_refused, n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/circular_deque.sv
bench/tb_top.sv
